// ===== design/hbf_pkg.sv =====
// Shared widths, limits, register indexes and payload types for the bond force pipeline.
package hbf_pkg;

  localparam int IDX_W  = 16;
  localparam int POS_W  = 32;
  localparam int R0_W   = 24;
  localparam int K_W    = 32;
  localparam int BOX_W  = 32;
  localparam int BOXD_W = 31;
  localparam int FRC_W  = 48;
  localparam int EN_W   = 48;

  // separation component, signed, magnitude <= 2^32 - 1
  localparam int DW     = POS_W + 1;
  // minimum-image divider: |2d + diag| magnitude and 2*diag
  localparam int WQ_W   = DW + 1;
  localparam int WD_W   = BOXD_W + 1;
  // squared length and its root
  localparam int SQ_W   = 2 * POS_W + 2;
  localparam int R_W    = 34;
  // |r - r0|
  localparam int AD_W   = R_W;
  // force divider
  localparam int NUM_W  = 99;
  localparam int FDEN_W = R_W + 8;
  localparam int FQ_W   = FRC_W;

  localparam logic signed [2*DW-1:0] DLIM_POS = 66'sd4294967295;
  localparam logic signed [2*DW-1:0] DLIM_NEG = -66'sd4294967295;
  localparam logic [FRC_W-1:0] FPOS = 48'h7FFF_FFFF_FFFF;
  localparam logic [FRC_W-1:0] FNEG = 48'h8000_0000_0000;
  localparam logic [EN_W-1:0]  ELIM = 48'hFFFF_FFFF_FFFF;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIODIC = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_A_X  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_B_X  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_B_Y  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_C_X  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_C_Y  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_C_Z  = 3'd6;

  typedef logic [2:0][DW-1:0] dvec_t;

  typedef struct packed {
    logic [IDX_W-1:0] a_idx;
    logic [IDX_W-1:0] b_idx;
    logic [K_W-1:0]   k;
    logic [R0_W-1:0]  r0;
  } bond_side_t;

  typedef struct packed {
    dvec_t      d;
    bond_side_t b;
  } item_t;

endpackage

// ===== design/hbf_udiv.sv =====
// Pipelined restoring divider, one quotient bit per stage, with side payload.
module hbf_udiv import hbf_pkg::*; #(
  parameter int NUM_W  = WQ_W,
  parameter int DEN_W  = WD_W,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [DEN_W-1:0]  in_rem,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [NUM_W-1:0]  out_quo,
  output logic [SIDE_W-1:0] out_side
);

  logic              v_r    [NUM_W];
  logic [DEN_W-1:0]  rem_r  [NUM_W];
  logic [NUM_W-1:0]  nq_r   [NUM_W];
  logic [DEN_W-1:0]  den_r  [NUM_W];
  logic [SIDE_W-1:0] side_r [NUM_W];

  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    logic              v_prev;
    logic [DEN_W-1:0]  rem_prev;
    logic [NUM_W-1:0]  nq_prev;
    logic [DEN_W-1:0]  den_prev;
    logic [SIDE_W-1:0] side_prev;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;

    if (s == 0) begin : g_first
      assign v_prev    = in_valid;
      assign rem_prev  = in_rem;
      assign nq_prev   = in_num;
      assign den_prev  = in_den;
      assign side_prev = in_side;
    end else begin : g_next
      assign v_prev    = v_r[s-1];
      assign rem_prev  = rem_r[s-1];
      assign nq_prev   = nq_r[s-1];
      assign den_prev  = den_r[s-1];
      assign side_prev = side_r[s-1];
    end

    assign trial = {rem_prev, nq_prev[NUM_W-1]};
    assign diff  = trial - {1'b0, den_prev};
    assign ge    = (trial >= {1'b0, den_prev});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (adv) begin
        v_r[s] <= v_prev;
      end
      if (adv) begin
        rem_r[s]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        nq_r[s]   <= {nq_prev[NUM_W-2:0], ge};
        den_r[s]  <= den_prev;
        side_r[s] <= side_prev;
      end
    end
  end

  assign out_valid = v_r[NUM_W-1];
  assign out_quo   = nq_r[NUM_W-1];
  assign out_side  = side_r[NUM_W-1];

endmodule

// ===== design/hbf_sqrt.sv =====
// Pipelined integer square root, one root bit per stage, with side payload.
module hbf_sqrt import hbf_pkg::*; #(
  parameter int RT_W   = R_W,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_valid,
  input  logic [SQ_W-1:0]   in_sq,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [RT_W-1:0]   out_root,
  output logic [SIDE_W-1:0] out_side
);

  localparam int SW    = 2 * RT_W;
  localparam int REM_W = RT_W + 3;

  logic              v_r    [RT_W];
  logic [REM_W-1:0]  rem_r  [RT_W];
  logic [RT_W-1:0]   root_r [RT_W];
  logic [SW-1:0]     sr_r   [RT_W];
  logic [SIDE_W-1:0] side_r [RT_W];

  for (genvar s = 0; s < RT_W; s++) begin : g_stage
    logic              v_prev;
    logic [REM_W-1:0]  rem_prev;
    logic [RT_W-1:0]   root_prev;
    logic [SW-1:0]     sr_prev;
    logic [SIDE_W-1:0] side_prev;
    logic [REM_W-1:0]  t;
    logic [REM_W-1:0]  trial;
    logic              ge;

    if (s == 0) begin : g_first
      assign v_prev    = in_valid;
      assign rem_prev  = '0;
      assign root_prev = '0;
      assign sr_prev   = SW'(in_sq);
      assign side_prev = in_side;
    end else begin : g_next
      assign v_prev    = v_r[s-1];
      assign rem_prev  = rem_r[s-1];
      assign root_prev = root_r[s-1];
      assign sr_prev   = sr_r[s-1];
      assign side_prev = side_r[s-1];
    end

    // remainder never exceeds twice the partial root
    assign t     = {rem_prev[REM_W-3:0], sr_prev[SW-1 -: 2]};
    assign trial = {1'b0, root_prev, 2'b01};
    assign ge    = (t >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (adv) begin
        v_r[s] <= v_prev;
      end
      if (adv) begin
        rem_r[s]  <= ge ? (t - trial) : t;
        root_r[s] <= {root_prev[RT_W-2:0], ge};
        sr_r[s]   <= {sr_prev[SW-3:0], 2'b00};
        side_r[s] <= side_prev;
      end
    end
  end

  assign out_valid = v_r[RT_W-1];
  assign out_root  = root_r[RT_W-1];
  assign out_side  = side_r[RT_W-1];

endmodule

// ===== design/hbf_wrap.sv =====
// One minimum-image step: divide for the image count, scale a box vector, subtract.
module hbf_wrap import hbf_pkg::*; #(
  parameter int COMP = 0
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic                    in_valid,
  input  item_t                   in_item,
  input  logic                    periodic_on,
  input  logic [BOXD_W-1:0]       diag,
  input  logic signed [BOX_W-1:0] vec_x,
  input  logic signed [BOX_W-1:0] vec_y,
  input  logic signed [BOX_W-1:0] vec_z,
  output logic                    out_valid,
  output item_t                   out_item
);

  typedef struct packed {
    logic  sgn;
    logic  skip;
    item_t item;
  } wside_t;

  localparam int SIDE_W = $bits(wside_t);
  localparam logic signed [WQ_W:0] N_HI = 35'sd2147483648;
  localparam logic signed [WQ_W:0] N_LO = -35'sd2147483648;

  logic [DW-1:0]   dc;
  logic [WQ_W:0]   num;
  wside_t          w0_side_nxt;

  logic            w0_v_r;
  logic [WQ_W-1:0] w0_u_r;
  logic [WD_W-1:0] w0_den_r;
  wside_t          w0_side_r;

  always_comb begin
    dc  = in_item.d[COMP];
    num = {dc[DW-1], dc, 1'b0} + {4'b0000, diag};
    w0_side_nxt.sgn  = num[WQ_W];
    w0_side_nxt.skip = !periodic_on || (diag == '0);
    w0_side_nxt.item = in_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w0_v_r <= 1'b0;
    end else if (adv) begin
      w0_v_r <= in_valid;
    end
    if (adv) begin
      // floor division of a negative numerator: ~(~num / den)
      w0_u_r    <= num[WQ_W-1:0] ^ {WQ_W{num[WQ_W]}};
      w0_den_r  <= {diag, 1'b0};
      w0_side_r <= w0_side_nxt;
    end
  end

  logic              q_v;
  logic [WQ_W-1:0]   q;
  logic [SIDE_W-1:0] q_side;
  wside_t            qs;

  hbf_udiv #(
    .NUM_W  (WQ_W),
    .DEN_W  (WD_W),
    .SIDE_W (SIDE_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (w0_v_r),
    .in_num    (w0_u_r),
    .in_rem    ('0),
    .in_den    (w0_den_r),
    .in_side   (w0_side_r),
    .out_valid (q_v),
    .out_quo   (q),
    .out_side  (q_side)
  );

  assign qs = q_side;

  logic [WQ_W:0]   nfull;
  logic [DW-1:0]   n_nxt;
  logic            w1_v_r;
  logic [DW-1:0]   w1_n_r;
  wside_t          w1_side_r;

  always_comb begin
    nfull = {1'b0, q} ^ {(WQ_W+1){qs.sgn}};
    priority if ($signed(nfull) > N_HI) begin
      n_nxt = N_HI[DW-1:0];
    end else if ($signed(nfull) < N_LO) begin
      n_nxt = N_LO[DW-1:0];
    end else begin
      n_nxt = nfull[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w1_v_r <= 1'b0;
    end else if (adv) begin
      w1_v_r <= q_v;
    end
    if (adv) begin
      w1_n_r    <= n_nxt;
      w1_side_r <= qs;
    end
  end

  logic                         w2_v_r;
  logic signed [BOX_W+DW-1:0]   w2_p_r [3];
  wside_t                       w2_side_r;
  logic signed [DW-1:0]         n_s;

  assign n_s = $signed(w1_n_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w2_v_r <= 1'b0;
    end else if (adv) begin
      w2_v_r <= w1_v_r;
    end
    if (adv) begin
      w2_p_r[0] <= vec_x * n_s;
      w2_p_r[1] <= vec_y * n_s;
      w2_p_r[2] <= vec_z * n_s;
      w2_side_r <= w1_side_r;
    end
  end

  item_t                 w3_nxt;
  logic [2*DW-1:0]       diff [3];

  always_comb begin
    w3_nxt = w2_side_r.item;
    for (int j = 0; j < 3; j++) begin
      diff[j] = {{DW{w2_side_r.item.d[j][DW-1]}}, w2_side_r.item.d[j]}
              - {w2_p_r[j][BOX_W+DW-1], w2_p_r[j]};
      if (!w2_side_r.skip) begin
        priority if ($signed(diff[j]) > DLIM_POS) begin
          w3_nxt.d[j] = DLIM_POS[DW-1:0];
        end else if ($signed(diff[j]) < DLIM_NEG) begin
          w3_nxt.d[j] = DLIM_NEG[DW-1:0];
        end else begin
          w3_nxt.d[j] = diff[j][DW-1:0];
        end
      end
    end
  end

  logic  w3_v_r;
  item_t w3_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w3_v_r <= 1'b0;
    end else if (adv) begin
      w3_v_r <= w2_v_r;
    end
    if (adv) begin
      w3_item_r <= w3_nxt;
    end
  end

  assign out_valid = w3_v_r;
  assign out_item  = w3_item_r;

endmodule

// ===== design/harmonic_bond_force.sv =====
// Harmonic bond force and energy pipeline, top level.
// Takes one bond word per clock while in_ready is high and returns one result word per bond, in
// order. The stages are the separation, the three minimum-image steps (their pipelined
// 34-stage dividers make up most of each), the squared length, the bit-per-stage square root,
// the product and sum stages, the force dividers and the output register. The whole pipeline
// holds while the output word waits, so a stall on the result side drops in_ready in the same
// cycle. Box registers are read live; write them only while the pipeline is empty.
module harmonic_bond_force import hbf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [IDX_W-1:0]     in_atom_a_index,
  input  logic [IDX_W-1:0]     in_atom_b_index,
  input  logic [POS_W-1:0]     in_a_x,
  input  logic [POS_W-1:0]     in_a_y,
  input  logic [POS_W-1:0]     in_a_z,
  input  logic [POS_W-1:0]     in_b_x,
  input  logic [POS_W-1:0]     in_b_y,
  input  logic [POS_W-1:0]     in_b_z,
  input  logic [R0_W-1:0]      in_ideal_length,
  input  logic [K_W-1:0]       in_spring_constant,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [IDX_W-1:0]     out_a_index,
  output logic [IDX_W-1:0]     out_b_index,
  output logic [FRC_W-1:0]     out_force_x,
  output logic [FRC_W-1:0]     out_force_y,
  output logic [FRC_W-1:0]     out_force_z,
  output logic [EN_W-1:0]      out_bond_energy,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BOX_W-1:0]     cfg_wdata
);

  localparam int ITEM_W = $bits(item_t);
  localparam int E_W    = 2 * AD_W + K_W + 2;
  localparam logic [E_W-1:0] E_RND = E_W'(1) << 24;

  // ---------------- configuration ----------------
  logic              periodic_r;
  logic [BOXD_W-1:0] box_a_x_r;
  logic [BOX_W-1:0]  box_b_x_r;
  logic [BOXD_W-1:0] box_b_y_r;
  logic [BOX_W-1:0]  box_c_x_r;
  logic [BOX_W-1:0]  box_c_y_r;
  logic [BOXD_W-1:0] box_c_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      periodic_r <= 1'b0;
      box_a_x_r  <= '0;
      box_b_x_r  <= '0;
      box_b_y_r  <= '0;
      box_c_x_r  <= '0;
      box_c_y_r  <= '0;
      box_c_z_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PERIODIC: periodic_r <= cfg_wdata[0];
        CFG_BOX_A_X:  box_a_x_r  <= cfg_wdata[BOXD_W-1:0];
        CFG_BOX_B_X:  box_b_x_r  <= cfg_wdata;
        CFG_BOX_B_Y:  box_b_y_r  <= cfg_wdata[BOXD_W-1:0];
        CFG_BOX_C_X:  box_c_x_r  <= cfg_wdata;
        CFG_BOX_C_Y:  box_c_y_r  <= cfg_wdata;
        CFG_BOX_C_Z:  box_c_z_r  <= cfg_wdata[BOXD_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- flow control ----------------
  logic out_valid_r;
  logic adv;

  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv;
  assign out_valid = out_valid_r;

  // ---------------- separation ----------------
  logic  s0_v_r;
  item_t s0_item_r;
  item_t s0_nxt;

  always_comb begin
    s0_nxt.d[0]    = {in_b_x[POS_W-1], in_b_x} - {in_a_x[POS_W-1], in_a_x};
    s0_nxt.d[1]    = {in_b_y[POS_W-1], in_b_y} - {in_a_y[POS_W-1], in_a_y};
    s0_nxt.d[2]    = {in_b_z[POS_W-1], in_b_z} - {in_a_z[POS_W-1], in_a_z};
    s0_nxt.b.a_idx = in_atom_a_index;
    s0_nxt.b.b_idx = in_atom_b_index;
    s0_nxt.b.k     = in_spring_constant;
    s0_nxt.b.r0    = in_ideal_length;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (adv) begin
      s0_v_r <= in_valid && in_ready;
    end
    if (adv) begin
      s0_item_r <= s0_nxt;
    end
  end

  // ---------------- minimum image: c, then b, then a ----------------
  logic  wz_v, wy_v, wx_v;
  item_t wz_item, wy_item, wx_item;

  hbf_wrap #(.COMP(2)) u_wrap_c (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .in_valid    (s0_v_r),
    .in_item     (s0_item_r),
    .periodic_on (periodic_r),
    .diag        (box_c_z_r),
    .vec_x       ($signed(box_c_x_r)),
    .vec_y       ($signed(box_c_y_r)),
    .vec_z       ($signed({1'b0, box_c_z_r})),
    .out_valid   (wz_v),
    .out_item    (wz_item)
  );

  hbf_wrap #(.COMP(1)) u_wrap_b (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .in_valid    (wz_v),
    .in_item     (wz_item),
    .periodic_on (periodic_r),
    .diag        (box_b_y_r),
    .vec_x       ($signed(box_b_x_r)),
    .vec_y       ($signed({1'b0, box_b_y_r})),
    .vec_z       ('0),
    .out_valid   (wy_v),
    .out_item    (wy_item)
  );

  hbf_wrap #(.COMP(0)) u_wrap_a (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .in_valid    (wy_v),
    .in_item     (wy_item),
    .periodic_on (periodic_r),
    .diag        (box_a_x_r),
    .vec_x       ($signed({1'b0, box_a_x_r})),
    .vec_y       ('0),
    .vec_z       ('0),
    .out_valid   (wx_v),
    .out_item    (wx_item)
  );

  // ---------------- squared length ----------------
  logic             m1_v_r, m2_v_r, m3_v_r;
  logic [POS_W-1:0] m1_mag_r [3];
  item_t            m1_item_r, m2_item_r, m3_item_r;
  logic [2*POS_W-1:0] m2_sq_r [3];
  logic [SQ_W-1:0]  m3_sum_r;
  logic [DW-1:0]    wx_neg [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wx_neg[i] = -wx_item.d[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
      m2_v_r <= 1'b0;
      m3_v_r <= 1'b0;
    end else if (adv) begin
      m1_v_r <= wx_v;
      m2_v_r <= m1_v_r;
      m3_v_r <= m2_v_r;
    end
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        m1_mag_r[i] <= wx_item.d[i][DW-1] ? wx_neg[i][POS_W-1:0] : wx_item.d[i][POS_W-1:0];
        m2_sq_r[i]  <= m1_mag_r[i] * m1_mag_r[i];
      end
      m1_item_r <= wx_item;
      m2_item_r <= m1_item_r;
      m3_sum_r  <= SQ_W'(m2_sq_r[0]) + SQ_W'(m2_sq_r[1]) + SQ_W'(m2_sq_r[2]);
      m3_item_r <= m2_item_r;
    end
  end

  // ---------------- square root ----------------
  logic              sq_v;
  logic [R_W-1:0]    sq_r;
  logic [ITEM_W-1:0] sq_side;
  item_t             sq_item;

  hbf_sqrt #(
    .RT_W   (R_W),
    .SIDE_W (ITEM_W)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (m3_v_r),
    .in_sq     (m3_sum_r),
    .in_side   (m3_item_r),
    .out_valid (sq_v),
    .out_root  (sq_r),
    .out_side  (sq_side)
  );

  assign sq_item = sq_side;

  // ---------------- F0: r - r0, magnitudes, signs ----------------
  logic [R_W:0]     rdiff;
  logic [R_W:0]     dist_neg;
  logic [DW-1:0]    sq_dneg [3];

  logic             f0_v_r;
  logic [AD_W-1:0]  f0_ad_r;
  logic [R_W-1:0]   f0_r_r;
  logic [2:0]       f0_neg_r;
  logic [POS_W-1:0] f0_mag_r [3];
  logic [K_W-1:0]   f0_k_r;
  logic [IDX_W-1:0] f0_aidx_r, f0_bidx_r;

  always_comb begin
    rdiff    = {1'b0, sq_r} - (R_W+1)'(sq_item.b.r0);
    dist_neg = -rdiff;
    for (int i = 0; i < 3; i++) begin
      sq_dneg[i] = -sq_item.d[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f0_v_r <= 1'b0;
    end else if (adv) begin
      f0_v_r <= sq_v;
    end
    if (adv) begin
      f0_ad_r <= rdiff[R_W] ? dist_neg[AD_W-1:0] : rdiff[AD_W-1:0];
      f0_r_r  <= sq_r;
      for (int i = 0; i < 3; i++) begin
        f0_neg_r[i] <= rdiff[R_W] ^ sq_item.d[i][DW-1];
        f0_mag_r[i] <= sq_item.d[i][DW-1] ? sq_dneg[i][POS_W-1:0]
                                          : sq_item.d[i][POS_W-1:0];
      end
      f0_k_r    <= sq_item.b.k;
      f0_aidx_r <= sq_item.b.a_idx;
      f0_bidx_r <= sq_item.b.b_idx;
    end
  end

  // ---------------- F1: k*|d|, (r - r0)^2 ----------------
  logic                 f1_v_r;
  logic [K_W+POS_W-1:0] f1_kd_r [3];
  logic [2*AD_W-1:0]    f1_ad2_r;
  logic [AD_W-1:0]      f1_ad_r;
  logic [R_W-1:0]       f1_r_r;
  logic [2:0]           f1_neg_r;
  logic [K_W-1:0]       f1_k_r;
  logic [IDX_W-1:0]     f1_aidx_r, f1_bidx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
    end else if (adv) begin
      f1_v_r <= f0_v_r;
    end
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        f1_kd_r[i] <= f0_k_r * f0_mag_r[i];
      end
      f1_ad2_r  <= f0_ad_r * f0_ad_r;
      f1_ad_r   <= f0_ad_r;
      f1_r_r    <= f0_r_r;
      f1_neg_r  <= f0_neg_r;
      f1_k_r    <= f0_k_r;
      f1_aidx_r <= f0_aidx_r;
      f1_bidx_r <= f0_bidx_r;
    end
  end

  // ---------------- F2: split partial products ----------------
  logic                  f2_v_r;
  logic [32+AD_W-1:0]    f2_lo_r [3];
  logic [32+AD_W-1:0]    f2_hi_r [3];
  logic [AD_W+K_W-1:0]   f2_elo_r, f2_ehi_r;
  logic [R_W-1:0]        f2_r_r;
  logic [2:0]            f2_neg_r;
  logic [IDX_W-1:0]      f2_aidx_r, f2_bidx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f2_v_r <= 1'b0;
    end else if (adv) begin
      f2_v_r <= f1_v_r;
    end
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        f2_lo_r[i] <= f1_kd_r[i][31:0] * f1_ad_r;
        f2_hi_r[i] <= f1_kd_r[i][K_W+POS_W-1:32] * f1_ad_r;
      end
      f2_elo_r  <= f1_ad2_r[AD_W-1:0] * f1_k_r;
      f2_ehi_r  <= f1_ad2_r[2*AD_W-1:AD_W] * f1_k_r;
      f2_r_r    <= f1_r_r;
      f2_neg_r  <= f1_neg_r;
      f2_aidx_r <= f1_aidx_r;
      f2_bidx_r <= f1_bidx_r;
    end
  end

  // ---------------- F3: numerators with rounding, energy sum ----------------
  logic              f3_v_r;
  logic [NUM_W-1:0]  f3_num_r [3];
  logic [FDEN_W-1:0] f3_den_r;
  logic [E_W-1:0]    f3_e_r;
  logic              f3_rz_r;
  logic [2:0]        f3_neg_r;
  logic [IDX_W-1:0]  f3_aidx_r, f3_bidx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f3_v_r <= 1'b0;
    end else if (adv) begin
      f3_v_r <= f2_v_r;
    end
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        f3_num_r[i] <= NUM_W'({f2_hi_r[i], 32'h0}) + NUM_W'(f2_lo_r[i])
                     + NUM_W'({f2_r_r, 7'h0});
      end
      f3_den_r  <= {f2_r_r, 8'h00};
      f3_e_r    <= E_W'({f2_ehi_r, {AD_W{1'b0}}}) + E_W'(f2_elo_r) + E_RND;
      f3_rz_r   <= (f2_r_r == '0);
      f3_neg_r  <= f2_neg_r;
      f3_aidx_r <= f2_aidx_r;
      f3_bidx_r <= f2_bidx_r;
    end
  end

  // ---------------- F4: overflow check, energy clamp ----------------
  typedef struct packed {
    logic             ovf;
    logic             rz;
    logic [2:0]       neg;
    logic [EN_W-1:0]  energy;
    logic [IDX_W-1:0] a_idx;
    logic [IDX_W-1:0] b_idx;
  } lane0_side_t;

  localparam int L0_W = $bits(lane0_side_t);

  logic              f4_v_r;
  logic [FQ_W-1:0]   f4_low_r [3];
  logic [FDEN_W-1:0] f4_rem_r [3];
  logic [2:0]        f4_ovf_r;
  logic [FDEN_W-1:0] f4_den_r;
  lane0_side_t       f4_side_r;
  logic [E_W-26:0]   e_sh;

  assign e_sh = f3_e_r[E_W-1:25];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f4_v_r <= 1'b0;
    end else if (adv) begin
      f4_v_r <= f3_v_r;
    end
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        // quotient needs more than FQ_W bits when the top part reaches the divisor
        f4_ovf_r[i] <= f3_num_r[i][NUM_W-1:FQ_W] >= (NUM_W-FQ_W)'(f3_den_r);
        f4_rem_r[i] <= f3_num_r[i][FQ_W+FDEN_W-1:FQ_W];
        f4_low_r[i] <= f3_num_r[i][FQ_W-1:0];
      end
      f4_den_r         <= f3_den_r;
      f4_side_r.ovf    <= 1'b0;
      f4_side_r.rz     <= f3_rz_r;
      f4_side_r.neg    <= f3_neg_r;
      f4_side_r.energy <= (e_sh > (E_W-25)'(ELIM)) ? ELIM : e_sh[EN_W-1:0];
      f4_side_r.a_idx  <= f3_aidx_r;
      f4_side_r.b_idx  <= f3_bidx_r;
    end
  end

  // ---------------- force dividers ----------------
  lane0_side_t     l0_in;
  logic            dv_v;
  logic [FQ_W-1:0] dv_q [3];
  logic [L0_W-1:0] dv_side0;
  logic            dv_ovf1, dv_ovf2;
  lane0_side_t     fin;

  always_comb begin
    l0_in     = f4_side_r;
    l0_in.ovf = f4_ovf_r[0];
  end

  hbf_udiv #(.NUM_W(FQ_W), .DEN_W(FDEN_W), .SIDE_W(L0_W)) u_fdiv_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (f4_v_r),
    .in_num    (f4_low_r[0]),
    .in_rem    (f4_rem_r[0]),
    .in_den    (f4_den_r),
    .in_side   (l0_in),
    .out_valid (dv_v),
    .out_quo   (dv_q[0]),
    .out_side  (dv_side0)
  );

  hbf_udiv #(.NUM_W(FQ_W), .DEN_W(FDEN_W), .SIDE_W(1)) u_fdiv_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (f4_v_r),
    .in_num    (f4_low_r[1]),
    .in_rem    (f4_rem_r[1]),
    .in_den    (f4_den_r),
    .in_side   (f4_ovf_r[1]),
    .out_valid (),
    .out_quo   (dv_q[1]),
    .out_side  (dv_ovf1)
  );

  hbf_udiv #(.NUM_W(FQ_W), .DEN_W(FDEN_W), .SIDE_W(1)) u_fdiv_z (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (f4_v_r),
    .in_num    (f4_low_r[2]),
    .in_rem    (f4_rem_r[2]),
    .in_den    (f4_den_r),
    .in_side   (f4_ovf_r[2]),
    .out_valid (),
    .out_quo   (dv_q[2]),
    .out_side  (dv_ovf2)
  );

  assign fin = dv_side0;

  // ---------------- saturate, sign, output register ----------------
  logic [2:0]       ovf;
  logic [FRC_W-1:0] lim  [3];
  logic [FRC_W-1:0] mag  [3];
  logic [FRC_W-1:0] frc_nxt [3];

  always_comb begin
    ovf = {dv_ovf2, dv_ovf1, fin.ovf};
    for (int i = 0; i < 3; i++) begin
      lim[i] = fin.neg[i] ? FNEG : FPOS;
      mag[i] = (ovf[i] || (dv_q[i] > lim[i])) ? lim[i] : dv_q[i];
      if (fin.rz) begin
        frc_nxt[i] = '0;
      end else begin
        frc_nxt[i] = fin.neg[i] ? -mag[i] : mag[i];
      end
    end
  end

  logic [FRC_W-1:0] frc_r [3];
  logic [EN_W-1:0]  energy_r;
  logic [IDX_W-1:0] aidx_r, bidx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_v;
    end
    if (adv) begin
      frc_r    <= frc_nxt;
      energy_r <= fin.energy;
      aidx_r   <= fin.a_idx;
      bidx_r   <= fin.b_idx;
    end
  end

  assign out_a_index     = aidx_r;
  assign out_b_index     = bidx_r;
  assign out_force_x     = frc_r[0];
  assign out_force_y     = frc_r[1];
  assign out_force_z     = frc_r[2];
  assign out_bond_energy = energy_r;

  // ---------------- checks ----------------
  a_zero_len_no_force: assert property (@(posedge clk) disable iff (!rst_n)
    adv && dv_v && fin.rz |=>
      out_force_x == '0 && out_force_y == '0 && out_force_z == '0)
    else $error("nonzero force for zero bond length");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output word valid right after reset");

  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(s0_v_r) && $stable(m3_v_r) && $stable(f4_v_r) && $stable(dv_v))
    else $error("pipeline moved while output stalled");

  a_lanes_agree: assert property (@(posedge clk) disable iff (!rst_n)
    adv && dv_v && !fin.rz && !fin.neg[0] |=> !out_force_x[FRC_W-1])
    else $error("positive x force came out negative");

endmodule

// ===== dv/tb_top.sv =====
// Testbench for the harmonic bond force pipeline: a directed table, then random bonds.
`timescale 1ns / 100ps
module tb_top;
  import hbf_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam int DRAIN_CYCLES = 250;

  typedef struct {
    logic [15:0] ai, bi;
    logic [31:0] ax, ay, az, bx, by, bz;
    logic [23:0] r0;
    logic [31:0] k;
  } bond_t;

  typedef struct {
    logic [15:0] ai, bi;
    logic [47:0] fx, fy, fz, en;
  } bond_res_t;

  typedef struct {
    bond_t     b;
    bit        typed;
    bond_res_t r;
  } dir_row_t;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [IDX_W-1:0] in_atom_a_index, in_atom_b_index, out_a_index, out_b_index;
  logic [POS_W-1:0] in_a_x, in_a_y, in_a_z, in_b_x, in_b_y, in_b_z;
  logic [R0_W-1:0] in_ideal_length;
  logic [K_W-1:0] in_spring_constant;
  logic [FRC_W-1:0] out_force_x, out_force_y, out_force_z;
  logic [EN_W-1:0] out_bond_energy;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BOX_W-1:0] cfg_wdata;

  harmonic_bond_force dut (.*);

  // shadow of the box registers
  bit     pbc_on;
  longint bax, bbx, bby, bcx, bcy, bcz;

  bond_res_t expected_q[$];
  dir_row_t  dir_rows[$];
  int  errors;
  bit  gaps_on;
  // idle cycles before the next input word, and whether valid is still up
  int  next_gap;
  bit  valid_held;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("harmonic_bond_force test failed");
    $finish;
  end

  function automatic longint sx32(logic [31:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint clamp_sep(longint v);
    if (v > 64'sd4294967295) return 64'sd4294967295;
    if (v < -64'sd4294967295) return -64'sd4294967295;
    return v;
  endfunction

  function automatic void image_step(ref longint d[3], input int comp, input longint diag,
                                     input longint vx, input longint vy, input longint vz);
    longint num, den, n;
    if (diag == 0) return;
    num = 2 * d[comp] + diag;
    den = 2 * diag;
    n = num / den;
    if (num % den != 0 && num < 0) n--;
    if (n > 64'sd2147483648) n = 64'sd2147483648;
    if (n < -64'sd2147483648) n = -64'sd2147483648;
    d[0] = clamp_sep(d[0] - vx * n);
    d[1] = clamp_sep(d[1] - vy * n);
    d[2] = clamp_sep(d[2] - vz * n);
  endfunction

  function automatic logic [127:0] mag64(longint v);
    return (v < 0) ? 128'(-v) : 128'(v);
  endfunction

  function automatic bond_res_t bond_force(bond_t b);
    bond_res_t res;
    longint d[3];
    logic [127:0] s, c, r, ad, num, den, q, lim;
    longint rdelta;
    bit neg;
    logic [47:0] fr[3];
    d[0] = sx32(b.bx) - sx32(b.ax);
    d[1] = sx32(b.by) - sx32(b.ay);
    d[2] = sx32(b.bz) - sx32(b.az);
    if (pbc_on) begin
      image_step(d, 2, bcz, bcx, bcy, bcz);
      image_step(d, 1, bby, bbx, bby, 0);
      image_step(d, 0, bax, bax, 0, 0);
    end
    s = mag64(d[0]) * mag64(d[0]) + mag64(d[1]) * mag64(d[1]) + mag64(d[2]) * mag64(d[2]);
    r = 0;
    for (int bt = 33; bt >= 0; bt--) begin
      c = r | (128'd1 << bt);
      if (c * c <= s) r = c;
    end
    rdelta = longint'(r[63:0]) - longint'({40'd0, b.r0});
    ad = mag64(rdelta);
    for (int i = 0; i < 3; i++) begin
      neg = (rdelta < 0) != (d[i] < 0);
      fr[i] = '0;
      if (r != 0) begin
        den = r << 8;
        num = 128'(b.k) * mag64(d[i]) * ad;
        q = (num + (den >> 1)) / den;
        lim = neg ? 128'(FNEG) : 128'(FPOS);
        if (q > lim) q = lim;
        fr[i] = neg ? 48'(-q) : q[47:0];
      end
    end
    q = (ad * ad * 128'(b.k) + (128'd1 << 24)) >> 25;
    res.en = (q > 128'(ELIM)) ? ELIM : q[47:0];
    res.ai = b.ai;
    res.bi = b.bi;
    res.fx = fr[0];
    res.fy = fr[1];
    res.fz = fr[2];
    return res;
  endfunction

  function automatic int gap_len();
    int p;
    if (!gaps_on) return 0;
    p = $urandom_range(0, 99);
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side stalls
  int stall_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      int g;
      g = gap_len();
      out_ready <= (g == 0);
      stall_left <= (g > 0) ? g - 1 : 0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      bond_res_t e;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word: a=%0d b=%0d", out_a_index,
                                   out_b_index);
      end else begin
        e = expected_q.pop_front();
        if (e.ai !== out_a_index || e.bi !== out_b_index || e.fx !== out_force_x ||
            e.fy !== out_force_y || e.fz !== out_force_z || e.en !== out_bond_energy) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch: exp idx %0d %0d f %h %h %h e %h", e.ai, e.bi, e.fx, e.fy,
                     e.fz, e.en);
            $display("          got idx %0d %0d f %h %h %h e %h", out_a_index, out_b_index,
                     out_force_x, out_force_y, out_force_z, out_bond_energy);
          end
        end
      end
    end
  end

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_PERIODIC: pbc_on = val[0];
      CFG_BOX_A_X:  bax = longint'(val[30:0]);
      CFG_BOX_B_X:  bbx = sx32(val);
      CFG_BOX_B_Y:  bby = longint'(val[30:0]);
      CFG_BOX_C_X:  bcx = sx32(val);
      CFG_BOX_C_Y:  bcy = sx32(val);
      CFG_BOX_C_Z:  bcz = longint'(val[30:0]);
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_box(bit pbc, logic [31:0] ax, logic [31:0] bx, logic [31:0] by,
                         logic [31:0] cx, logic [31:0] cy, logic [31:0] cz);
    cfg_write(CFG_PERIODIC, {31'd0, pbc});
    cfg_write(CFG_BOX_A_X, ax);
    cfg_write(CFG_BOX_B_X, bx);
    cfg_write(CFG_BOX_B_Y, by);
    cfg_write(CFG_BOX_C_X, cx);
    cfg_write(CFG_BOX_C_Y, cy);
    cfg_write(CFG_BOX_C_Z, cz);
  endtask

  // one bond word; result is the typed one if given, else the predicted one
  task automatic send_bond(bond_t b, bit typed, bond_res_t r);
    repeat (next_gap) @(posedge clk);
    in_valid <= 1'b1;
    in_atom_a_index <= b.ai;
    in_atom_b_index <= b.bi;
    in_a_x <= b.ax; in_a_y <= b.ay; in_a_z <= b.az;
    in_b_x <= b.bx; in_b_y <= b.by; in_b_z <= b.bz;
    in_ideal_length <= b.r0;
    in_spring_constant <= b.k;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_q.push_back(typed ? r : bond_force(b));
    // keep valid up only when the next word goes straight out
    next_gap = gap_len();
    valid_held = (next_gap == 0);
    if (!valid_held) in_valid <= 1'b0;
  endtask

  task automatic drop_valid();
    if (valid_held) in_valid <= 1'b0;
    valid_held = 0;
  endtask

  task automatic drain();
    drop_valid();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [31:0] srand_range(int span);
    return 32'($urandom_range(0, 2 * span) - span);
  endfunction

  function automatic bond_t rand_bond(int span);
    bond_t b;
    b.ai = 16'($urandom); b.bi = 16'($urandom);
    if ($urandom_range(0, 9) < 2) begin
      b.ax = $urandom; b.ay = $urandom; b.az = $urandom;
      b.bx = $urandom; b.by = $urandom; b.bz = $urandom;
    end else begin
      b.ax = $urandom; b.ay = $urandom; b.az = $urandom;
      b.bx = b.ax + srand_range(span);
      b.by = b.ay + srand_range(span);
      b.bz = b.az + srand_range(span);
    end
    b.r0 = ($urandom_range(0, 9) < 2) ? 24'($urandom) : 24'($urandom_range(0, 200000));
    b.k = ($urandom_range(0, 9) < 2) ? $urandom : $urandom_range(0, 32'h00FF_FFFF);
    return b;
  endfunction

  function automatic void add_row(logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                                  logic [31:0] bx, logic [31:0] by, logic [31:0] bz,
                                  logic [23:0] r0, logic [31:0] k, logic [15:0] ai,
                                  logic [15:0] bi, bit typed, logic [47:0] f,
                                  logic [47:0] en);
    dir_row_t row;
    row.b = '{ai, bi, ax, ay, az, bx, by, bz, r0, k};
    row.typed = typed;
    row.r = '{ai, bi, f, f, f, en};
    dir_rows.push_back(row);
  endfunction

  initial begin
    bond_res_t none;
    errors = 0;
    gaps_on = 1;
    next_gap = 0;
    valid_held = 0;
    none = '{0, 0, 0, 0, 0, 0};
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_atom_a_index <= '0; in_atom_b_index <= '0;
    in_a_x <= '0; in_a_y <= '0; in_a_z <= '0;
    in_b_x <= '0; in_b_y <= '0; in_b_z <= '0;
    in_ideal_length <= '0; in_spring_constant <= '0;
    cfg_we <= 1'b0; cfg_index <= '0; cfg_wdata <= '0;
    pbc_on = 0; bax = 0; bbx = 0; bby = 0; bcx = 0; bcy = 0; bcz = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero separation: no force, energy from r0 alone
    add_row(0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 16'h0000, 16'hFFFF, 1, 48'd0, 48'd0);
    add_row(5, 6, 7, 5, 6, 7, 24'h01_0000, 32'd512, 16'hFFFF, 16'h0000, 1, 48'd0, 48'd65536);
    // far corners, stiffest spring: everything saturates
    add_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            32'h7FFF_FFFF, 0, 32'hFFFF_FFFF, 1, 2, 1, FPOS, ELIM);
    add_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
            32'h8000_0000, 0, 32'hFFFF_FFFF, 3, 4, 1, FNEG, ELIM);
    add_row(0, 0, 0, 32'h0001_0000, 0, 0, 24'hFF_FFFF, 32'h100, 5, 6, 0, 0, 0);
    add_row(0, 0, 0, 0, 32'hFFFF_0000, 0, 24'h00_8000, 32'h1234, 7, 8, 0, 0, 0);
    add_row(0, 0, 0, 0, 0, 1, 0, 32'h0000_0100, 9, 10, 0, 0, 0);
    add_row(0, 0, 0, 0, 0, 1, 24'h00_0002, 32'd1, 11, 12, 0, 0, 0);
    add_row(32'h0003_0000, 32'hFFFD_0000, 32'h0000_8000, 32'h0001_0000, 32'h0002_0000,
            32'hFFFF_8000, 24'h02_0000, 32'h0010_0000, 13, 14, 0, 0, 0);
    add_row(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h5555_5555,
            32'hAAAA_AAAA, 24'hFF_FFFF, 32'hFFFF_FFFF, 15, 16, 0, 0, 0);
    add_row(0, 0, 0, 32'h0000_0003, 32'h0000_0004, 0, 24'h00_0005, 32'h0000_0200, 17, 18, 0, 0,
            0);
    foreach (dir_rows[i]) send_bond(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].r);
    drain();

    // reduced triclinic box, about 5 nm edges
    set_box(1, 32'h0005_0000, 32'h0001_8000, 32'h0004_C000, 32'hFFFE_C000, 32'h0001_0000,
            32'h0004_8000);
    cfg_write(CFG_UNUSED, 32'hFFFF_FFFF);
    // periodic bonds crossing directed across the wrap
    send_bond('{1, 2, 32'h0000_1000, 0, 0, 32'h0004_F000, 0, 0, 24'h00_2000, 32'h0001_0000},
              0, none);
    send_bond('{3, 4, 0, 0, 32'hFFFC_0000, 0, 0, 32'h0004_0000, 0, 32'h0001_0000}, 0, none);
    for (int i = 0; i < 300; i++) send_bond(rand_bond(32'h000C_0000), 0, none);
    drain();

    // periodic on, zero diagonals: every step skipped; no gaps anywhere here
    gaps_on = 0;
    set_box(1, 0, 32'h7FFF_FFFF, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0);
    for (int i = 0; i < 150; i++) send_bond(rand_bond(32'h0010_0000), 0, none);
    drain();
    gaps_on = 1;

    // largest box and most negative skews
    set_box(1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
            32'h7FFF_FFFF);
    for (int i = 0; i < 150; i++) send_bond(rand_bond(32'h7FFF_FFFF), 0, none);
    drain();

    // tiny box, random skews: many image shifts
    set_box(1, 32'h0000_0001 + $urandom_range(0, 32'h2_0000), $urandom,
            32'h0000_0001 + $urandom_range(0, 32'h2_0000), $urandom, $urandom,
            32'h0000_0001 + $urandom_range(0, 32'h2_0000));
    for (int i = 0; i < 200; i++) send_bond(rand_bond(32'h0100_0000), 0, none);
    drain();

    // back to open boundaries with junk box values
    set_box(0, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    for (int i = 0; i < 200; i++) send_bond(rand_bond(32'h0004_0000), 0, none);
    drop_valid();

    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("harmonic_bond_force test passed");
    end else begin
      $display("harmonic_bond_force test failed");
    end
    $finish;
  end

endmodule

// ===== harmonic_bond_force.f =====
design/hbf_pkg.sv
design/hbf_udiv.sv
design/hbf_sqrt.sv
design/hbf_wrap.sv
design/harmonic_bond_force.sv
dv/tb_top.sv
